// ----- sv/complex_magnitude_core_macros.svh -----
// Assertion macros shared by the complex magnitude core.
// Needs a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef COMPLEX_MAGNITUDE_CORE_MACROS_SVH
`define COMPLEX_MAGNITUDE_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CMAG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CMAG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/cmag_pkg.sv -----
// Shared widths and stage types for the complex magnitude core.
// No dependencies; imported by every module of the core.
`timescale 1ns / 1ps

package cmag_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int MAG_WIDTH    = 16;
  localparam int RAD_WIDTH    = 2 * SAMPLE_WIDTH;
  localparam int REM_WIDTH    = SAMPLE_WIDTH + 2;

  // Squared-sum stage output.
  typedef struct packed {
    logic                 last;
    logic [RAD_WIDTH-1:0] rad;
  } cmag_sq_t;

  // Data handed from one square-root cell to the next.
  typedef struct packed {
    logic                    last;
    logic [RAD_WIDTH-1:0]    rad;
    logic [REM_WIDTH-1:0]    rem;
    logic [SAMPLE_WIDTH-1:0] root;
  } cmag_cell_t;

  // One finished result beat.
  typedef struct packed {
    logic                 last;
    logic [MAG_WIDTH-1:0] mag;
  } cmag_res_t;

endpackage

// ----- sv/cmag_square.sv -----
// Absolute value, squaring and sum of squares, two register stages.
// Depends on cmag_pkg.
`timescale 1ns / 1ps

module cmag_square
  import cmag_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic signed [SAMPLE_WIDTH-1:0] re,
  input  logic signed [SAMPLE_WIDTH-1:0] im,
  input  logic                           last,
  output logic                           sq_valid,
  output cmag_sq_t                       sq_data
);

  logic [SAMPLE_WIDTH-1:0] re_u, im_u, re_abs, im_abs;
  logic [RAD_WIDTH-1:0]    re_sq_nxt, im_sq_nxt, re_sq_r, im_sq_r;
  logic                    mul_valid_r, mul_last_r;
  logic                    sum_valid_r;
  cmag_sq_t                sum_r, sum_nxt;

  always_comb begin
    re_u   = re;
    im_u   = im;
    re_abs = re_u[SAMPLE_WIDTH-1] ? (~re_u + 1'b1) : re_u;
    im_abs = im_u[SAMPLE_WIDTH-1] ? (~im_u + 1'b1) : im_u;
    re_sq_nxt = {{SAMPLE_WIDTH{1'b0}}, re_abs} * {{SAMPLE_WIDTH{1'b0}}, re_abs};
    im_sq_nxt = {{SAMPLE_WIDTH{1'b0}}, im_abs} * {{SAMPLE_WIDTH{1'b0}}, im_abs};
    // The sum is at most 2^(2*SAMPLE_WIDTH-1), so it fits without a carry bit.
    sum_nxt.rad  = re_sq_r + im_sq_r;
    sum_nxt.last = mul_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
      sum_valid_r <= 1'b0;
    end else if (en) begin
      mul_valid_r <= in_valid;
      sum_valid_r <= mul_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      re_sq_r    <= re_sq_nxt;
      im_sq_r    <= im_sq_nxt;
      mul_last_r <= last;
      sum_r      <= sum_nxt;
    end
  end

  assign sq_valid = sum_valid_r;
  assign sq_data  = sum_r;

endmodule

// ----- sv/cmag_sqrt_cell.sv -----
// One cell of the square-root row: settles one result bit per cycle while en is high.
// Depends on cmag_pkg.
`timescale 1ns / 1ps

module cmag_sqrt_cell
  import cmag_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       cell_valid_in,
  input  cmag_cell_t cell_in,
  output logic       cell_valid_out,
  output cmag_cell_t cell_out
);

  logic [REM_WIDTH+1:0] acc, trial, diff;
  logic                 fits;
  logic                 valid_r;
  cmag_cell_t           data_r, data_nxt;

  always_comb begin
    // Bring down the next two radicand bits and try the bit one.
    acc   = {cell_in.rem, cell_in.rad[RAD_WIDTH-1 -: 2]};
    trial = {{(REM_WIDTH-SAMPLE_WIDTH){1'b0}}, cell_in.root, 2'b01};
    diff  = acc - trial;
    fits  = (acc >= trial);
    data_nxt.last = cell_in.last;
    data_nxt.rad  = {cell_in.rad[RAD_WIDTH-3:0], 2'b00};
    data_nxt.rem  = fits ? diff[REM_WIDTH-1:0] : acc[REM_WIDTH-1:0];
    data_nxt.root = {cell_in.root[SAMPLE_WIDTH-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= cell_valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign cell_valid_out = valid_r;
  assign cell_out       = data_r;

endmodule

// ----- sv/cmag_skid.sv -----
// Output register with a spare entry that decouples the result side.
// Depends on cmag_pkg and complex_magnitude_core_macros.svh.
`timescale 1ns / 1ps
`include "complex_magnitude_core_macros.svh"

module cmag_skid
  import cmag_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 inc_valid,
  input  cmag_res_t            inc_data,
  output logic                 spare_full,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [MAG_WIDTH-1:0] out_magnitude,
  output logic                 out_last_out
);

  logic      out_valid_r, out_valid_nxt;
  logic      spare_valid_r, spare_valid_nxt;
  cmag_res_t out_data_r, out_data_nxt;
  cmag_res_t spare_data_r, spare_data_nxt;
  logic      take;

  always_comb begin
    take            = out_valid_r && !out_stall;
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;
    spare_valid_nxt = spare_valid_r;
    spare_data_nxt  = spare_data_r;
    if (spare_valid_r) begin
      // The row is frozen; only drain the spare.
      if (take) begin
        out_data_nxt    = spare_data_r;
        spare_valid_nxt = 1'b0;
      end
    end else if (!out_valid_r || take) begin
      out_valid_nxt = inc_valid;
      out_data_nxt  = inc_data;
    end else if (inc_valid) begin
      spare_valid_nxt = 1'b1;
      spare_data_nxt  = inc_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      spare_valid_r <= 1'b0;
    end else begin
      out_valid_r   <= out_valid_nxt;
      spare_valid_r <= spare_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r   <= out_data_nxt;
    spare_data_r <= spare_data_nxt;
  end

  assign spare_full    = spare_valid_r;
  assign out_valid     = out_valid_r;
  assign out_magnitude = out_data_r.mag;
  assign out_last_out  = out_data_r.last;

  `CMAG_ASSERT_NOW(a_spare_needs_out, spare_valid_r, out_valid_r, "spare held without output beat")
  `CMAG_ASSERT_NEXT(a_spare_fills, out_valid_r && out_stall && inc_valid && !spare_valid_r, spare_valid_r, "arriving beat lost while output stalled")
  `CMAG_ASSERT_NEXT(a_spare_drains, spare_valid_r && !out_stall, !spare_valid_r && out_valid_r, "spare not moved to output")

endmodule

// ----- sv/complex_magnitude_core.sv -----
// Complex magnitude core: floor(sqrt(re^2 + im^2)) of one sample per beat.
// A beat passes the squaring stages, the square-root row and the output register.
// One sample per cycle unless in_stall is high, set by a row of one root cell per result bit.
// Reset is synchronous and active low; it empties the row and the output stage.
// Depends on cmag_pkg, cmag_square, cmag_sqrt_cell, cmag_skid.
`timescale 1ns / 1ps

module complex_magnitude_core
  import cmag_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_real_part,
  input  logic signed [SAMPLE_WIDTH-1:0] in_imag_part,
  input  logic                           in_last_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [MAG_WIDTH-1:0]           out_magnitude,
  output logic                           out_last_out
);

  // The whole arithmetic row moves together. It only halts when the output
  // stage has both its registers occupied, which is a registered condition,
  // so the input stall never depends combinationally on the output stall.
  logic       spare_full;
  logic       en;
  logic       sq_valid;
  cmag_sq_t   sq_data;
  logic       chain_valid [SAMPLE_WIDTH+1];
  cmag_cell_t chain_data  [SAMPLE_WIDTH+1];
  cmag_res_t  res_data;

  assign en       = !spare_full;
  assign in_stall = spare_full;

  // Two stages: magnitudes of the parts are squared, then the squares summed.
  cmag_square u_square (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .re       (in_real_part),
    .im       (in_imag_part),
    .last     (in_last_in),
    .sq_valid (sq_valid),
    .sq_data  (sq_data)
  );

  // The first cell starts from an empty remainder and an empty root.
  assign chain_valid[0]     = sq_valid;
  assign chain_data[0].last = sq_data.last;
  assign chain_data[0].rad  = sq_data.rad;
  assign chain_data[0].rem  = '0;
  assign chain_data[0].root = '0;

  // Digit-by-digit square root: cell k decides root bit SAMPLE_WIDTH-1-k,
  // consuming two radicand bits and passing the partial root and remainder on.
  for (genvar k = 0; k < SAMPLE_WIDTH; k++) begin : g_cell
    cmag_sqrt_cell u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .en             (en),
      .cell_valid_in  (chain_valid[k]),
      .cell_in        (chain_data[k]),
      .cell_valid_out (chain_valid[k+1]),
      .cell_out       (chain_data[k+1])
    );
  end

  // The magnitude field is fixed in width; the root is fitted to it.
  if (SAMPLE_WIDTH >= MAG_WIDTH) begin : g_mag_trim
    assign res_data.mag = chain_data[SAMPLE_WIDTH].root[MAG_WIDTH-1:0];
  end else begin : g_mag_pad
    assign res_data.mag = {{(MAG_WIDTH-SAMPLE_WIDTH){1'b0}}, chain_data[SAMPLE_WIDTH].root};
  end
  assign res_data.last = chain_data[SAMPLE_WIDTH].last;

  // Output register plus a spare entry, so a stalled result beat does not
  // stop the row until a second finished result arrives behind it.
  cmag_skid u_skid (
    .clk           (clk),
    .rst_n         (rst_n),
    .inc_valid     (chain_valid[SAMPLE_WIDTH]),
    .inc_data      (res_data),
    .spare_full    (spare_full),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_magnitude (out_magnitude),
    .out_last_out  (out_last_out)
  );

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for complex_magnitude_core: drives complex samples and checks each
// magnitude and last flag against an exact integer square root computed alongside.
// Depends on cmag_pkg and the complex_magnitude_core RTL; reads and writes no files.
`timescale 1ns / 1ps

module tb
  import cmag_pkg::*;
;

  // Longest run of cycles with no beat on either channel before the run is abandoned.
  // The worst correct case is the long receiver hold-off below, well under this.
  localparam int WATCHDOG_LIMIT = 5000;
  // Length of the deliberate receiver hold-off, in cycles.
  localparam int HOLD_CYCLES    = 300;
  // Cycles to wait after the last result, well over the pipeline latency.
  localparam int TAIL_CYCLES    = SAMPLE_WIDTH + 3 + 20;
  // Least number of random samples per phase, three phases in all.
  localparam int PHASE_SAMPLES  = 533;

  // The scoreboard keeps its own predictor. Every accepted input beat gets its expected
  // result computed here and queued; every accepted output beat is checked against the oldest
  // entry in the queue. The block carries nothing from one sample to the next, so a sample's result depends
  // on nothing but the sample itself.
  class magnitude_scoreboard;
    cmag_res_t outstanding_q[$];
    int        errors;
    int        samples_seen;
    int        vectors_seen;
    int        results_checked;

    // Exact floor(sqrt(re^2 + im^2)). The parts are widened before negation, so the most
    // negative value gives its true size instead of wrapping. The root is built one bit at a
    // time from the top, keeping each bit whose square still fits under the sum of squares.
    function logic [MAG_WIDTH-1:0] exact_magnitude(logic signed [SAMPLE_WIDTH-1:0] re,
                                                   logic signed [SAMPLE_WIDTH-1:0] im);
      longint unsigned re_size;
      longint unsigned im_size;
      longint unsigned power;
      longint unsigned root;
      longint unsigned trial;
      int              k;
      re_size = (re < 0) ? longint'(-longint'(re)) : longint'(re);
      im_size = (im < 0) ? longint'(-longint'(im)) : longint'(im);
      power   = re_size * re_size + im_size * im_size;
      root    = 0;
      for (k = SAMPLE_WIDTH; k >= 0; k--) begin
        trial = root | (longint'(1) << k);
        if (trial * trial <= power) begin
          root = trial;
        end
      end
      return root[MAG_WIDTH-1:0];
    endfunction

    function void note_sample(logic signed [SAMPLE_WIDTH-1:0] re,
                              logic signed [SAMPLE_WIDTH-1:0] im, logic last);
      cmag_res_t want;
      want.mag  = exact_magnitude(re, im);
      want.last = last;
      outstanding_q.push_back(want);
      samples_seen++;
      if (last) begin
        vectors_seen++;
      end
    endfunction

    function void check_result(logic [MAG_WIDTH-1:0] mag, logic last);
      cmag_res_t want;
      if (outstanding_q.size() == 0) begin
        if (errors < 10) begin
          $display("%0t: result beat with nothing outstanding: magnitude %0d last %0b",
                   $realtime, mag, last);
        end
        errors++;
        return;
      end
      want = outstanding_q.pop_front();
      results_checked++;
      if (mag !== want.mag || last !== want.last) begin
        if (errors < 10) begin
          $display("%0t: result %0d wrong: magnitude %0d (expected %0d), last %0b (expected %0b)",
                   $realtime, results_checked, mag, want.mag, last, want.last);
        end
        errors++;
      end
    endfunction

    function int pending();
      return outstanding_q.size();
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  logic signed [SAMPLE_WIDTH-1:0] in_real_part;
  logic signed [SAMPLE_WIDTH-1:0] in_imag_part;
  logic                           in_last_in;
  logic                           out_valid;
  logic                           out_stall;
  logic [MAG_WIDTH-1:0]           out_magnitude;
  logic                           out_last_out;

  // Percentages of idle cycles on each side, changed from phase to phase.
  int  send_idle_pct;
  int  recv_stall_pct;
  // Raised by the stimulus to ask the receiver for one long hold-off.
  logic hold_req;
  int   quiet_cycles;

  magnitude_scoreboard sb = new();

  complex_magnitude_core u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_real_part  (in_real_part),
    .in_imag_part  (in_imag_part),
    .in_last_in    (in_last_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_magnitude (out_magnitude),
    .out_last_out  (out_last_out)
  );

  // 12 ns clock; the first rising edge falls at 6 ns, after every input has a known value.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Both channels are observed at the rising edge, where every signal still holds the value
  // it settled to in the previous cycle, so the order in which processes wake does not matter.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_sample(in_real_part, in_imag_part, in_last_in);
      end
      if (out_valid && !out_stall) begin
        sb.check_result(out_magnitude, out_last_out);
      end
    end
  end

  // Watchdog: the run is abandoned once no beat has moved on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d results still outstanding",
                 $realtime, quiet_cycles, sb.pending());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Receiver. Normally it stalls at random at the rate of the current phase. When asked for a
  // hold-off it stalls for a fixed count of cycles, counted here, so that the pipeline fills
  // behind the stall and the block has to stall its own input.
  initial begin : receiver
    int held;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        for (held = 0; held < HOLD_CYCLES; held++) begin
          @(posedge clk);
        end
        hold_req  <= 1'b0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Offers one sample and returns at the edge that accepts it. Any idle gap is decided before
  // the beat is offered, so valid never depends on stall, and the payload holds while stalled.
  task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] re,
                             input logic signed [SAMPLE_WIDTH-1:0] im, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_real_part <= re;
    in_imag_part <= im;
    in_last_in   <= last;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  // Holds the sender back until every result owed has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  // Random sample part: mostly uniform over the full range, with the two extremes and values
  // close to zero mixed in so that tiny and saturating magnitudes turn up often.
  function automatic logic signed [SAMPLE_WIDTH-1:0] random_part();
    logic signed [SAMPLE_WIDTH-1:0] part;
    case ($urandom_range(9))
      0:       part = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      1:       part = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      2:       part = SAMPLE_WIDTH'(int'($urandom_range(31)) - 16);
      default: part = SAMPLE_WIDTH'($urandom);
    endcase
    return part;
  endfunction

  initial begin : stimulus
    logic signed [SAMPLE_WIDTH-1:0] most_neg;
    logic signed [SAMPLE_WIDTH-1:0] most_pos;
    int phase;
    int sent;
    int vec_len;
    int n;

    most_neg       = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    most_pos       = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_real_part   = '0;
    in_imag_part   = '0;
    in_last_in     = 1'b0;
    out_stall      = 1'b0;
    hold_req       = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    quiet_cycles   = 0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed samples, back to back: the zero sample, the most negative part on its own and
    // on both sides (the largest magnitude of all), the most positive parts, a sign mix,
    // unit samples, a Pythagorean triple and alternating bit patterns, with the last flag
    // both low and high.
    send_sample('0, '0, 1'b0);
    send_sample(most_neg, '0, 1'b0);
    send_sample('0, most_neg, 1'b1);
    send_sample(most_neg, most_neg, 1'b0);
    send_sample(most_pos, most_pos, 1'b1);
    send_sample(most_neg, most_pos, 1'b0);
    send_sample(most_pos, most_neg, 1'b1);
    send_sample(most_pos, '0, 1'b0);
    send_sample(SAMPLE_WIDTH'(1), '0, 1'b0);
    send_sample('0, SAMPLE_WIDTH'(-1), 1'b1);
    send_sample(SAMPLE_WIDTH'(-1), SAMPLE_WIDTH'(-1), 1'b0);
    send_sample(SAMPLE_WIDTH'(3), SAMPLE_WIDTH'(-4), 1'b0);
    send_sample(SAMPLE_WIDTH'(-3), SAMPLE_WIDTH'(4), 1'b1);
    send_sample(SAMPLE_WIDTH'(16'h5555), SAMPLE_WIDTH'(16'hAAAA), 1'b0);
    send_sample(SAMPLE_WIDTH'(16'hAAAA), SAMPLE_WIDTH'(16'h5555), 1'b1);
    send_sample(SAMPLE_WIDTH'(16'h7FFE), SAMPLE_WIDTH'(16'h8001), 1'b1);
    drain_results();

    // Random vectors in three phases: a slow receiver, then a slow sender, then neither idling.
    // The last phase opens with the long receiver hold-off while the sender keeps offering.
    // Between phases the sender waits until every result is back.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 31;
          recv_stall_pct = 88;
        end
        1: begin
          send_idle_pct  = 88;
          recv_stall_pct = 31;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_req      <= 1'b1;
        end
      endcase
      sent = 0;
      while (sent < PHASE_SAMPLES) begin
        vec_len = $urandom_range(1, 24);
        for (n = 0; n < vec_len; n++) begin
          send_sample(random_part(), random_part(), n == vec_len - 1);
        end
        sent += vec_len;
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d samples in %0d vectors, %0d results checked, %0d errors.",
             sb.samples_seen, sb.vectors_seen, sb.results_checked, sb.errors);
    $display("Phases ran with a slow receiver, a slow sender, no idling and a %0d-cycle hold-off.",
             HOLD_CYCLES);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
